// ===== rtl/htl_pkg.sv =====
// ----------------------------------------------------------------------------
// htl_pkg: shared types and constants for the tree lock engine
// Tree geometry, request descriptor passed from front to back, command codes
// and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package htl_pkg;

  localparam int NODES       = 256;
  localparam int SLOT_W      = $clog2(NODES);          // slot index width
  localparam int CFG_W       = 9;                      // node_count register width
  localparam int MAX_ANC     = SLOT_W;                 // deepest slot has this many ancestors
  localparam int LVL_W       = $clog2(MAX_ANC + 1);
  localparam int PATH_IDX_W  = $clog2(MAX_ANC);
  localparam int BELOW_W     = 8;                      // locked-descendant count width
  localparam int ENTRY_W     = BELOW_W + 1;            // {flag, count}
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [LVL_W-1:0]  level;     // number of ancestors of slot
    logic              in_range;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } back_state_e;

  function automatic logic [SLOT_W-1:0] parent_of(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] m;
    m = s - SLOT_W'(1);
    return m >> 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hierarchical_tree_lock_engine.sv =====
// ----------------------------------------------------------------------------
// hierarchical_tree_lock_engine: lock manager for a level-order binary tree
// Grants or refuses lock/unlock requests on tree slots, keeping per-slot lock
// flags and locked-descendant counts.
// ----------------------------------------------------------------------------
// A request (cmd_i, slot_i) is taken on a clock edge with start high and busy
// low; up to two requests queue up while one executes. Each request produces
// exactly one done_o pulse carrying granted_o, in request order, and done_o
// cannot be held off. Execution walks the slot and its ancestors through a
// single-port node store, one node per cycle: a slot at depth L (root is 0,
// L up to 8) is read towards the root, stopping at the first failing node,
// and is walked again writing the new flag and counts if all pass; a slot at or
// beyond node_count is answered without a walk. node_count is written with
// node_count_we_i and should only change while no request is outstanding.
`default_nettype none

module hierarchical_tree_lock_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        node_count_we_i,
  input  wire logic [htl_pkg::CFG_W-1:0]   node_count_i,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd_i,
  input  wire logic [htl_pkg::SLOT_W-1:0]  slot_i,
  output logic                             done_o,
  output logic                             granted_o
);
  import htl_pkg::*;

  logic push, pop, full, empty;
  req_t front_req, queue_req;

  htl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_count_we_i (node_count_we_i),
    .node_count_i    (node_count_i),
    .start           (start),
    .cmd_i           (cmd_i),
    .slot_i          (slot_i),
    .full_i          (full),
    .push_o          (push),
    .req_o           (front_req)
  );

  htl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .req_o   (queue_req)
  );

  htl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .req_i     (queue_req),
    .pop_o     (pop),
    .done_o    (done_o),
    .granted_o (granted_o)
  );

  assign busy = full;

endmodule

`default_nettype wire

// ===== rtl/htl_front.sv =====
// ----------------------------------------------------------------------------
// htl_front: request intake and classification
// Holds node_count, checks the slot against it and works out the slot depth,
// then hands a descriptor to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         node_count_we_i,
  input  wire logic [htl_pkg::CFG_W-1:0]    node_count_i,
  input  wire logic                         start,
  input  wire logic                         cmd_i,
  input  wire logic [htl_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic                         full_i,
  output logic                              push_o,
  output htl_pkg::req_t                     req_o
);
  import htl_pkg::*;

  logic [CFG_W-1:0]  node_count_q;
  logic [SLOT_W:0]   slot_p1;
  logic [LVL_W-1:0]  level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (node_count_we_i) begin
      node_count_q <= node_count_i;
    end
  end

  // depth = floor(log2(slot+1))
  assign slot_p1 = {1'b0, slot_i} + (SLOT_W + 1)'(1);

  always_comb begin
    level = '0;
    for (int i = 0; i <= SLOT_W; i++) begin
      if (slot_p1[i]) level = LVL_W'(i);
    end
  end

  assign push_o         = start && !full_i;
  assign req_o.cmd      = cmd_i;
  assign req_o.slot     = slot_i;
  assign req_o.level    = level;
  assign req_o.in_range = (CFG_W'(slot_i) < node_count_q);

endmodule

`default_nettype wire

// ===== rtl/htl_queue.sv =====
// ----------------------------------------------------------------------------
// htl_queue: request queue between front and back
// Small FIFO of classified requests so intake and execution stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire htl_pkg::req_t req_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               empty_o,
  output htl_pkg::req_t      req_o
);
  import htl_pkg::*;

  req_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/htl_back.sv =====
// ----------------------------------------------------------------------------
// htl_back: lock executor
// Walks from the target slot up to the root through the single-port node
// store, checking flags and collecting ancestor counts, then walks again
// writing the new flag and adjusted counts when the request is granted.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire htl_pkg::req_t req_i,
  output logic               pop_o,
  output logic               done_o,
  output logic               granted_o
);
  import htl_pkg::*;

  back_state_e        state_q, state_d;
  req_t               req_q, req_d;
  logic [SLOT_W-1:0]  addr_q, addr_d;
  logic [LVL_W-1:0]   idx_q, idx_d;
  logic [BELOW_W-1:0] path_q [MAX_ANC];
  logic [BELOW_W-1:0] path_d [MAX_ANC];
  logic               done_q, done_d;
  logic               granted_q, granted_d;

  // node store: {flag, locked_below}; entries without a valid bit read as zero
  logic [ENTRY_W-1:0] mem [NODES];
  logic [NODES-1:0]   valid_q;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data, rd_entry;

  logic               flag;
  logic [BELOW_W-1:0] count, cnt_old, cnt_new;
  logic               want_locked, pass;
  logic [LVL_W-1:0]   idx_m1;
  logic [SLOT_W-1:0]  parent;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  assign rd_entry    = rd_vld_q ? rd_data_q : '0;
  assign flag        = rd_entry[ENTRY_W-1];
  assign count       = rd_entry[BELOW_W-1:0];
  assign want_locked = (req_q.cmd == CMD_UNLOCK);
  assign idx_m1      = idx_q - LVL_W'(1);
  assign parent      = parent_of(addr_q);
  assign cnt_old     = path_q[idx_m1[PATH_IDX_W-1:0]];

  always_comb begin
    if (req_q.cmd == CMD_LOCK) begin
      cnt_new = cnt_old + BELOW_W'(1);
    end else if (cnt_old != '0) begin
      cnt_new = cnt_old - BELOW_W'(1);
    end else begin
      cnt_new = cnt_old;
    end
  end

  // target must hold the opposite of the requested flag with nothing locked below;
  // every ancestor must be unlocked
  assign pass = (idx_q == '0) ? ((flag == want_locked) && (count == '0)) : !flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    addr_q <= addr_d;
    idx_q  <= idx_d;
    path_q <= path_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    path_d    = path_q;
    pop_o     = 1'b0;
    rd_addr   = addr_q;
    wr_en     = 1'b0;
    wr_addr   = addr_q;
    wr_data   = '0;
    done_d    = 1'b0;
    granted_d = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          req_d = req_i;
          if (!req_i.in_range) begin
            done_d = 1'b1;
          end else begin
            rd_addr = req_i.slot;
            addr_d  = req_i.slot;
            idx_d   = '0;
            state_d = BK_READ;
          end
        end
      end
      BK_READ: begin
        // data for addr_q arrives now; fetch its parent meanwhile
        rd_addr = parent;
        if (idx_q != '0) path_d[idx_m1[PATH_IDX_W-1:0]] = count;
        if (!pass) begin
          done_d  = 1'b1;
          state_d = BK_IDLE;
        end else if (idx_q == req_q.level) begin
          addr_d  = req_q.slot;
          idx_d   = '0;
          state_d = BK_WRITE;
        end else begin
          addr_d = parent;
          idx_d  = idx_q + LVL_W'(1);
        end
      end
      BK_WRITE: begin
        wr_en = 1'b1;
        if (idx_q == '0) begin
          wr_data = {!want_locked, BELOW_W'(0)};
        end else begin
          wr_data = {1'b0, cnt_new};
        end
        if (idx_q == req_q.level) begin
          done_d    = 1'b1;
          granted_d = 1'b1;
          state_d   = BK_IDLE;
        end else begin
          addr_d = parent;
          idx_d  = idx_q + LVL_W'(1);
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign done_o    = done_q;
  assign granted_o = granted_q;

endmodule

`default_nettype wire

// ===== rtl/htl_checker.sv =====
// ----------------------------------------------------------------------------
// htl_checker: port-level checks for the tree lock engine
// Tracks outstanding requests and checks results against them.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire logic granted_o
);

  logic       accept;
  logic [2:0] pend_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({accept, done_o})
        2'b10:   pend_q <= pend_q + 3'd1;
        2'b01:   pend_q <= pend_q - 3'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  a_grant_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_o |-> done_o)
    else $error("granted without result strobe");

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pend_q != 3'd0))
    else $error("result without an outstanding request");

  a_busy_when_backed_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pend_q >= 3'd2))
    else $error("busy with fewer than two requests outstanding");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd3) |-> busy)
    else $error("accepting beyond queue capacity");

endmodule

bind hierarchical_tree_lock_engine htl_checker u_htl_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .granted_o (granted_o)
);

`default_nettype wire
